// ----- rtl/vcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Velocity command smoother package
// Shared widths, register indexes, reset values, stage structs and the
// divide-by-1.3 helper used by the smoother datapath.
// ----------------------------------------------------------------------------
package vcs_pkg;

	localparam int VEL_W   = 16;               // velocity word, signed
	localparam int FRAC_W  = 10;               // fraction bits of all fixed point values
	localparam int TIME_W  = 16;               // elapsed time word, unsigned
	localparam int CFG_W   = 16;               // configuration register width
	localparam int PROD_W  = CFG_W + TIME_W;   // rate times time product
	localparam int CORR_W  = PROD_W - FRAC_W + 1; // rounded correction term
	localparam int IDX_W   = 2;                // register index width

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_LIN_LIMIT = 2'd0;
	localparam logic [IDX_W-1:0] REG_ANG_LIMIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_ANG_DECEL = 2'd2;

	// Register reset values.
	localparam logic [CFG_W-1:0] LIN_LIMIT_RST = 16'd1024;
	localparam logic [CFG_W-1:0] ANG_LIMIT_RST = 16'd1024;
	localparam logic [CFG_W-1:0] ANG_DECEL_RST = 16'd102;

	// Divide by 13 as a multiply by a rounded-up reciprocal. With a shift of
	// 24 the error term stays below one for every numerator under 2^19.
	localparam int                DIV_N_W     = VEL_W + 4;
	localparam int                DIV_SHIFT   = 24;
	localparam int                DIV_K_W     = 21;
	localparam logic [DIV_K_W-1:0] DIV_K      = 21'd1290556;
	localparam int                DIV_P_W     = DIV_N_W + DIV_K_W;

	typedef logic signed [VEL_W-1:0] vel_t;

	// Item after the first stage: command, zero-time flag, time-scaled thresholds, correction.
	typedef struct packed {
		vel_t              lin;
		vel_t              ang;
		logic              time_zero;
		logic [PROD_W-1:0] lin_thr;
		logic [PROD_W-1:0] ang_thr;
		logic [CORR_W-1:0] corr;
	} prep_t;

	// Smoother state carried from one command to the next.
	typedef struct packed {
		logic have_prev;
		vel_t prev_lin;
		vel_t prev_ang;
		vel_t last_lin;
		vel_t last_ang;
	} state_t;

	typedef struct packed {
		logic ang_limited;
		logic lin_limited;
		vel_t ang;
		vel_t lin;
	} result_t;

	// Value divided by 1.3, rounded to nearest, sign kept.
	function automatic vel_t div_1_3(input vel_t v);
		logic [VEL_W-1:0]   m;
		logic [DIV_N_W-1:0] n;
		logic [DIV_P_W-1:0] p;
		logic [VEL_W-1:0]   q;
		m = v[VEL_W-1] ? VEL_W'(-v) : VEL_W'(v);
		n = DIV_N_W'(m) * DIV_N_W'(10) + DIV_N_W'(6);
		p = DIV_P_W'(n) * DIV_P_W'(DIV_K);
		q = p[DIV_SHIFT +: VEL_W];
		return v[VEL_W-1] ? vel_t'(-q) : vel_t'(q);
	endfunction

endpackage

// ----- rtl/vcs_calc.sv -----
// ----------------------------------------------------------------------------
// Velocity command smoother step
// Applies the linear and angular limits to one prepared command against the
// stored state, and gives the result and the next state.
// ----------------------------------------------------------------------------
module vcs_calc (
	input  vcs_pkg::prep_t   prep,
	input  vcs_pkg::state_t  state,
	output vcs_pkg::result_t res,
	output logic             has_result,
	output vcs_pkg::state_t  state_nxt
);

	localparam int DW = vcs_pkg::VEL_W + 1;
	localparam int SW = vcs_pkg::CORR_W + 1;

	logic signed [DW-1:0] dlin;
	logic signed [DW-1:0] dang;
	logic [vcs_pkg::VEL_W-1:0] alin;
	logic [vcs_pkg::VEL_W-1:0] aang;
	logic [vcs_pkg::PROD_W-1:0] dlin_sc;
	logic [vcs_pkg::PROD_W-1:0] dang_sc;
	logic lin_lim;
	logic ang_lim;
	vcs_pkg::vel_t lin_o;
	vcs_pkg::vel_t sign_src;
	logic neg;
	logic pos;
	logic signed [SW-1:0] ang_ext;
	logic signed [SW-1:0] corr_ext;
	logic signed [SW-1:0] ang_sum;
	vcs_pkg::vel_t ang_sat;
	vcs_pkg::vel_t ang_o;

	always_comb begin
		dlin = DW'(state.prev_lin) - DW'(prep.lin);
		dang = DW'(state.prev_ang) - DW'(prep.ang);
		alin = dlin[DW-1] ? vcs_pkg::VEL_W'(-dlin) : vcs_pkg::VEL_W'(dlin);
		aang = dang[DW-1] ? vcs_pkg::VEL_W'(-dang) : vcs_pkg::VEL_W'(dang);
		dlin_sc = vcs_pkg::PROD_W'(alin) << vcs_pkg::FRAC_W;
		dang_sc = vcs_pkg::PROD_W'(aang) << vcs_pkg::FRAC_W;
		lin_lim = dlin_sc > prep.lin_thr;
		ang_lim = dang_sc > prep.ang_thr;

		lin_o = lin_lim ? vcs_pkg::div_1_3(state.prev_lin) : prep.lin;
		// Dividing keeps the sign and never turns a nonzero value into zero,
		// so the steering direction can be taken from the undivided value.
		sign_src = lin_lim ? state.prev_lin : prep.lin;
		neg = sign_src[vcs_pkg::VEL_W-1];
		pos = !neg && (sign_src != '0);

		ang_ext  = SW'(prep.ang);
		corr_ext = $signed({1'b0, prep.corr});
		ang_sum  = neg ? (ang_ext + corr_ext) : (ang_ext - corr_ext);
		if (ang_sum > SW'(signed'({1'b0, {(vcs_pkg::VEL_W-1){1'b1}}}))) begin
			ang_sat = {1'b0, {(vcs_pkg::VEL_W-1){1'b1}}};
		end else if (ang_sum < SW'(signed'({1'b1, {(vcs_pkg::VEL_W-1){1'b0}}}))) begin
			ang_sat = {1'b1, {(vcs_pkg::VEL_W-1){1'b0}}};
		end else begin
			ang_sat = ang_sum[vcs_pkg::VEL_W-1:0];
		end
		ang_o = (ang_lim && (neg || pos)) ? ang_sat : prep.ang;

		state_nxt = state;
		state_nxt.have_prev = 1'b1;
		res.lin = state.last_lin;
		res.ang = state.last_ang;
		res.lin_limited = 1'b0;
		res.ang_limited = 1'b0;
		has_result = state.have_prev;

		if (!state.have_prev || prep.time_zero) begin
			// Priming command or zero elapsed time: store the command as is.
			state_nxt.prev_lin = prep.lin;
			state_nxt.prev_ang = prep.ang;
		end else begin
			res.lin = lin_o;
			res.ang = ang_o;
			res.lin_limited = lin_lim;
			res.ang_limited = ang_lim;
			state_nxt.prev_lin = lin_o;
			state_nxt.prev_ang = ang_o;
			state_nxt.last_lin = lin_o;
			state_nxt.last_ang = ang_o;
		end
	end

endmodule

// ----- rtl/velocity_command_smoother.sv -----
// ----------------------------------------------------------------------------
// Velocity command smoother
// Limits linear and angular acceleration of a stream of velocity commands.
// ----------------------------------------------------------------------------
// A request is held in the input register, and its result is loaded into the
// output register when the request leaves the input register.
// Throughput: one request per cycle when the output is not stalled. A stalled
// result holds the input register, so the block then holds two requests.
// Reset clears the registers to their reset values, forgets the previous
// command and empties the pipeline; the first request after reset gives no result.
module velocity_command_smoother (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [vcs_pkg::IDX_W-1:0] cfg_index,
	input  logic [vcs_pkg::CFG_W-1:0] cfg_data,
	// Command stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // linear_in[15:0], angular_in[31:16], elapsed_time[47:32]
	// Smoothed command stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // linear_out[15:0], angular_out[31:16],
	                                   // linear_limited[32], angular_limited[33], zeros above
);

	// Configuration registers.
	logic [vcs_pkg::CFG_W-1:0] lin_limit_q;
	logic [vcs_pkg::CFG_W-1:0] ang_limit_q;
	logic [vcs_pkg::CFG_W-1:0] ang_decel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_limit_q <= vcs_pkg::LIN_LIMIT_RST;
			ang_limit_q <= vcs_pkg::ANG_LIMIT_RST;
			ang_decel_q <= vcs_pkg::ANG_DECEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vcs_pkg::REG_LIN_LIMIT: lin_limit_q <= cfg_data;
				vcs_pkg::REG_ANG_LIMIT: ang_limit_q <= cfg_data;
				vcs_pkg::REG_ANG_DECEL: ang_decel_q <= cfg_data;
				default: ;  // Unmapped index, the write is dropped.
			endcase
		end
	end

	// Pipeline handshake. The input register takes a new request when it is
	// empty or hands its own request on in the same cycle, so requests can
	// follow each other with no gap while the output keeps moving.
	logic            vld_s1;
	logic            out_vld_q;
	logic [47:0]     in_s1;
	vcs_pkg::prep_t  prep_d;
	vcs_pkg::state_t state_q;
	vcs_pkg::state_t state_nxt;
	vcs_pkg::result_t res;
	vcs_pkg::result_t out_q;
	logic            has_result;
	logic            out_ready;
	logic            s1_fire;
	logic            in_fire;

	assign out_ready     = !out_vld_q || m_axis_tready;
	// A priming request leaves the input register without needing the output
	// register.
	assign s1_fire       = vld_s1 && (out_ready || !has_result);
	assign s_axis_tready = !vld_s1 || s1_fire;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			state_q   <= '0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (s1_fire && has_result) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (s1_fire) begin
				state_q <= state_nxt;
			end
		end
	end

	// The time-scaled thresholds and the rounded angular correction depend
	// only on the request and the registers.
	logic [vcs_pkg::TIME_W-1:0] time_s1;
	logic [vcs_pkg::PROD_W:0]   decel_prod;

	always_comb begin
		time_s1 = in_s1[47:32];
		prep_d.lin       = in_s1[15:0];
		prep_d.ang       = in_s1[31:16];
		prep_d.time_zero = (time_s1 == '0);
		prep_d.lin_thr   = vcs_pkg::PROD_W'(lin_limit_q) * vcs_pkg::PROD_W'(time_s1);
		prep_d.ang_thr   = vcs_pkg::PROD_W'(ang_limit_q) * vcs_pkg::PROD_W'(time_s1);
		// Round to nearest with halves going up.
		decel_prod = (vcs_pkg::PROD_W+1)'(vcs_pkg::PROD_W'(ang_decel_q)
			* vcs_pkg::PROD_W'(time_s1))
			+ (vcs_pkg::PROD_W+1)'(1 << (vcs_pkg::FRAC_W - 1));
		prep_d.corr = decel_prod[vcs_pkg::PROD_W:vcs_pkg::FRAC_W];
	end

	// Limit checks against the stored state.
	vcs_calc u_calc (
		.prep       (prep_d),
		.state      (state_q),
		.res        (res),
		.has_result (has_result),
		.state_nxt  (state_nxt)
	);

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_s1 <= s_axis_tdata;
		end
		if (s1_fire && has_result) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'b0, out_q};

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Velocity command smoother testbench
// Streams velocity commands into the smoother and checks every smoothed
// result against a cycle-free model of the limiting rules. The run covers
// directed corner cases, register extremes, output back-pressure and long
// random phases with varied register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;

	// Cycles to let pass after the last expected result before touching the
	// registers. The block holds at most two requests, so this covers a
	// request that produces no result but is still in flight.
	localparam int SETTLE_CYCLES = 8;
	// Length of the long output hold-off used to fill the pipeline.
	localparam int HOLD_CYCLES   = 300;
	// Longest idle gap the sender inserts before one request.
	localparam int MAX_GAP       = 40;
	// The one register index that maps to no register.
	localparam logic [vcs_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

	// One smoothed command as the block should report it.
	typedef struct {
		vcs_pkg::vel_t lin;
		vcs_pkg::vel_t ang;
		bit            lin_limited;
		bit            ang_limited;
	} smoothed_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [vcs_pkg::IDX_W-1:0]  cfg_index;
	logic [vcs_pkg::CFG_W-1:0]  cfg_data;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [47:0]                s_axis_tdata;   // linear_in, angular_in, elapsed_time from bit 0 up
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [39:0]                m_axis_tdata;   // linear_out, angular_out, linear_limited,
	                                            // angular_limited from bit 0 up, zeros above

	// Model copy of the register file.
	logic [vcs_pkg::CFG_W-1:0]  lin_limit;
	logic [vcs_pkg::CFG_W-1:0]  ang_limit;
	logic [vcs_pkg::CFG_W-1:0]  ang_decel;

	// Model copy of the smoother state.
	bit                         have_previous;
	vcs_pkg::vel_t              prev_lin;
	vcs_pkg::vel_t              prev_ang;
	vcs_pkg::vel_t              last_lin;
	vcs_pkg::vel_t              last_ang;

	// Results the block still owes, oldest first.
	smoothed_t                  expected_smoothed[$];
	smoothed_t                  expected_now;

	// Idle control for the sender and the receiver.
	int                         sender_idle_pct;
	int                         receiver_stall_pct;
	int                         hold_len;
	int                         hold_count;

	// Run statistics.
	int                         mismatch_count;
	int                         commands_sent;
	int                         results_checked;
	int                         lin_limited_seen;
	int                         ang_limited_seen;
	int                         settings_used;

	velocity_command_smoother dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A hard stop in case a handshake never completes. A correct run needs
	// well under a tenth of this.
	initial begin
		#2000000;
		$display("velocity_command_smoother test failed");
		$finish;
	end

	// Saturate a wide value to the velocity range.
	function automatic vcs_pkg::vel_t clamp_vel(input longint v);
		if (v > 32767)
			return vcs_pkg::vel_t'(32767);
		if (v < -32768)
			return vcs_pkg::vel_t'(-32768);
		return vcs_pkg::vel_t'(v);
	endfunction

	// Register values spread over all magnitudes, not just large ones.
	function automatic logic [vcs_pkg::CFG_W-1:0] spread_value();
		return vcs_pkg::CFG_W'($urandom_range(65535) >> $urandom_range(15));
	endfunction

	// One of the velocity values at the ends of the range or at or next to zero.
	function automatic int extreme_value();
		case ($urandom_range(4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// Apply one accepted command to the model state and queue the result it
	// causes. The very first command after reset only primes the state. A zero
	// elapsed time repeats the last result with both flags clear. Otherwise the
	// linear output falls back to the previous linear divided by 1.3 when the
	// change is too fast, and the angular output is moved by decel times time,
	// down for a positive and up for a negative linear output, when the
	// angular change is too fast; a zero linear output leaves it unchanged.
	task automatic smooth_command(input vcs_pkg::vel_t lin, input vcs_pkg::vel_t ang,
		input logic [15:0] dt);
		longint lin_step;
		longint ang_step;
		longint lin_next;
		longint ang_next;
		longint mag;
		longint corr;
		smoothed_t res;
		if (!have_previous) begin
			have_previous = 1'b1;
			prev_lin = lin;
			prev_ang = ang;
			return;
		end
		res.lin_limited = 1'b0;
		res.ang_limited = 1'b0;
		if (dt == 16'd0) begin
			// The new command is remembered as is, the output does not move.
			prev_lin = lin;
			prev_ang = ang;
		end else begin
			lin_next = lin;
			ang_next = ang;
			lin_step = longint'(prev_lin) - longint'(lin);
			if (lin_step < 0)
				lin_step = -lin_step;
			ang_step = longint'(prev_ang) - longint'(ang);
			if (ang_step < 0)
				ang_step = -ang_step;
			if ((lin_step << vcs_pkg::FRAC_W) > longint'(lin_limit) * longint'(dt)) begin
				// Divide by 1.3 as times 10 over 13, rounded to nearest, sign kept.
				mag = (prev_lin < 0) ? -longint'(prev_lin) : longint'(prev_lin);
				mag = (mag * 10 + 6) / 13;
				lin_next = (prev_lin < 0) ? -mag : mag;
				res.lin_limited = 1'b1;
			end
			if ((ang_step << vcs_pkg::FRAC_W) > longint'(ang_limit) * longint'(dt)) begin
				corr = (longint'(ang_decel) * longint'(dt)
					+ (longint'(1) << (vcs_pkg::FRAC_W - 1))) >> vcs_pkg::FRAC_W;
				// With a zero linear output the commanded angular passes through.
				if (lin_next < 0)
					ang_next = clamp_vel(longint'(ang) + corr);
				else if (lin_next > 0)
					ang_next = clamp_vel(longint'(ang) - corr);
				res.ang_limited = 1'b1;
			end
			last_lin = vcs_pkg::vel_t'(lin_next);
			last_ang = vcs_pkg::vel_t'(ang_next);
			prev_lin = last_lin;
			prev_ang = last_ang;
		end
		res.lin = last_lin;
		res.ang = last_ang;
		expected_smoothed.insert(expected_smoothed.size(), res);
	endtask

	// Print one line per mismatch and count all of them.
	task automatic report_mismatch(input string field, input logic [15:0] got,
		input logic [15:0] want);
		$display("MISMATCH at %0t, result %0d, %s: got %h, expected %h",
			$realtime, results_checked, field, got, want);
		mismatch_count++;
	endtask

	// Result checker. Every accepted result is compared field by field with
	// the oldest outstanding prediction. The padding bits above the flags must
	// read zero as well.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_smoothed.size() == 0) begin
				report_mismatch("result with nothing expected", m_axis_tdata[15:0], '0);
			end else begin
				expected_now = expected_smoothed.pop_front();
				if (m_axis_tdata[15:0] !== expected_now.lin)
					report_mismatch("linear_out", m_axis_tdata[15:0], expected_now.lin);
				if (m_axis_tdata[31:16] !== expected_now.ang)
					report_mismatch("angular_out", m_axis_tdata[31:16], expected_now.ang);
				if (m_axis_tdata[32] !== expected_now.lin_limited)
					report_mismatch("linear_limited", 16'(m_axis_tdata[32]),
						16'(expected_now.lin_limited));
				if (m_axis_tdata[33] !== expected_now.ang_limited)
					report_mismatch("angular_limited", 16'(m_axis_tdata[33]),
						16'(expected_now.ang_limited));
				if (m_axis_tdata[39:34] !== '0)
					report_mismatch("padding", 16'(m_axis_tdata[39:34]), '0);
				if (expected_now.lin_limited)
					lin_limited_seen++;
				if (expected_now.ang_limited)
					ang_limited_seen++;
			end
			results_checked++;
		end
	end

	// Output side. It stalls at random with the current percentage. When a
	// hold-off is requested it keeps tready low for the whole count, so the
	// pipeline fills and the block has to stall its input.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				hold_count = hold_len;
				hold_len <= 0;
				m_axis_tready <= 1'b0;
				repeat (hold_count) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Offer one command request, after a random idle gap, and wait until it is
	// accepted. tvalid stays high afterwards so back-to-back requests do not
	// toggle it; the next gap or the drain lowers it.
	task automatic send_command(input int lin, input int ang, input int dt);
		int gap;
		vcs_pkg::vel_t lin_v;
		vcs_pkg::vel_t ang_v;
		logic [15:0] dt_v;
		lin_v = vcs_pkg::vel_t'(lin);
		ang_v = vcs_pkg::vel_t'(ang);
		dt_v = 16'(dt);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {dt_v, ang_v, lin_v};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		smooth_command(lin_v, ang_v, dt_v);
		commands_sent++;
	endtask

	// Stop sending and wait until every predicted result has come out, then
	// let the pipeline run empty.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_smoothed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Single register write. The enable is lowered again before the task returns,
	// so that two writes in a row never lower and raise the enable in the same step.
	task automatic write_register(input logic [vcs_pkg::IDX_W-1:0] idx,
		input logic [vcs_pkg::CFG_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			vcs_pkg::REG_LIN_LIMIT: lin_limit = value;
			vcs_pkg::REG_ANG_LIMIT: ang_limit = value;
			vcs_pkg::REG_ANG_DECEL: ang_decel = value;
			default: ;
		endcase
	endtask

	// Reprogram all three registers once the block has gone quiet.
	task automatic set_limits(input logic [vcs_pkg::CFG_W-1:0] lin_value,
		input logic [vcs_pkg::CFG_W-1:0] ang_value,
		input logic [vcs_pkg::CFG_W-1:0] decel_value);
		drain_results();
		write_register(vcs_pkg::REG_LIN_LIMIT, lin_value);
		write_register(vcs_pkg::REG_ANG_LIMIT, ang_value);
		write_register(vcs_pkg::REG_ANG_DECEL, decel_value);
		settings_used++;
	endtask

	// Directed cases at the reset register values: the priming command, a zero
	// time before any result, in-limit changes, linear and angular limiting
	// with positive, negative and zero linear output, range extremes and a
	// repeated output on zero time.
	task automatic test_directed_commands();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		settings_used++;
		send_command(100, -50, 5);          // primes only, no result
		send_command(200, 300, 0);          // zero time before any result: zeros out
		send_command(210, 305, 1024);       // small change, passes through
		send_command(30000, 305, 1);        // linear jump, falls back to previous / 1.3
		send_command(0, 0, 65535);          // longest time allows any change
		send_command(0, 20000, 10);         // angular limited with zero linear
		send_command(-1000, -1000, 65535);
		send_command(-1000, 8000, 8000);    // angular limited, negative linear: pushed up
		send_command(1000, 8797, 65535);
		send_command(1000, -20000, 20000);  // angular limited, positive linear: pushed down
		send_command(-32768, 32767, 65535);
		send_command(32767, -32768, 1);     // both limited from the range ends
		send_command(5, 5, 0);              // repeats the last result
		send_command(-7, 9, 0);
		drain_results();
	endtask

	// Register extremes: a zero angular limit with the largest decel rate
	// drives the angular output into saturation both ways, a write to the
	// unused index must change nothing, and a zero linear limit lets only an
	// unchanged command through.
	task automatic test_register_extremes();
		set_limits(16'hFFFF, 16'd0, 16'hFFFF);
		write_register(REG_SPARE, 16'd1);
		send_command(32767, 32767, 65535);      // saturates low
		send_command(-32768, 32767, 65535);     // saturates high
		drain_results();
		write_register(vcs_pkg::REG_LIN_LIMIT, 16'd0);
		send_command(-32768, 32767, 1);         // same as stored: no limiting
		send_command(-32767, 32767, 1);         // any change trips a zero limit
		send_command(12345, -32768, 65535);
	endtask

	// Long receiver hold-off while the sender keeps offering requests back to
	// back, then a full pause until every result is out.
	task automatic test_backpressure();
		int n;
		set_limits(vcs_pkg::LIN_LIMIT_RST, vcs_pkg::ANG_LIMIT_RST, vcs_pkg::ANG_DECEL_RST);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_len <= HOLD_CYCLES;
		for (n = 0; n < 40; n++)
			send_command(int'(vcs_pkg::vel_t'($urandom())), int'(vcs_pkg::vel_t'($urandom())),
				int'($urandom_range(2000)));
		drain_results();
	endtask

	// Random phases. Most commands follow a slowly moving trend so the limits
	// are sometimes met and sometimes just missed; the rest are full-range
	// jumps, zero-time repeats and range extremes.
	task automatic test_random_commands();
		int phase;
		int n;
		int pick;
		int lin_val;
		int ang_val;
		int trend_lin;
		int trend_ang;
		logic [15:0] dt;
		trend_lin = 0;
		trend_ang = 0;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_limits(vcs_pkg::LIN_LIMIT_RST, vcs_pkg::ANG_LIMIT_RST,
					vcs_pkg::ANG_DECEL_RST);
				1: set_limits(16'd0, 16'd0, 16'hFFFF);
				2: set_limits(16'hFFFF, 16'hFFFF, 16'd0);
				default: set_limits(spread_value(), spread_value(), spread_value());
			endcase
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 83;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 83;
				end
				default: begin
					sender_idle_pct = 30;
					receiver_stall_pct = 30;
				end
			endcase
			for (n = 0; n < 220; n++) begin
				pick = $urandom_range(99);
				if ($urandom_range(99) < 70)
					dt = 16'($urandom_range(255, 1));
				else
					dt = 16'($urandom_range(65535, 1));
				if (pick < 60) begin
					lin_val = trend_lin + int'($urandom_range(256)) - 128;
					ang_val = trend_ang + int'($urandom_range(256)) - 128;
				end else if (pick < 78) begin
					lin_val = int'(vcs_pkg::vel_t'($urandom()));
					ang_val = int'(vcs_pkg::vel_t'($urandom()));
				end else if (pick < 88) begin
					lin_val = trend_lin + int'($urandom_range(64)) - 32;
					ang_val = trend_ang + int'($urandom_range(64)) - 32;
					dt = 16'd0;
				end else begin
					lin_val = extreme_value();
					ang_val = extreme_value();
					dt = $urandom_range(1) ? 16'hFFFF : 16'd1;
				end
				trend_lin = int'(clamp_vel(lin_val));
				trend_ang = int'(clamp_vel(ang_val));
				send_command(trend_lin, trend_ang, int'(dt));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_len = 0;
		mismatch_count = 0;
		commands_sent = 0;
		results_checked = 0;
		lin_limited_seen = 0;
		ang_limited_seen = 0;
		settings_used = 0;
		lin_limit = vcs_pkg::LIN_LIMIT_RST;
		ang_limit = vcs_pkg::ANG_LIMIT_RST;
		ang_decel = vcs_pkg::ANG_DECEL_RST;
		have_previous = 1'b0;
		prev_lin = '0;
		prev_ang = '0;
		last_lin = '0;
		last_ang = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_commands();
		test_register_extremes();
		test_backpressure();
		test_random_commands();
		drain_results();

		$display("Summary: %0d commands over %0d register settings, %0d results checked.",
			commands_sent, settings_used, results_checked);
		$display("Summary: linear limiting %0d times, angular limiting %0d times, %0d mismatches.",
			lin_limited_seen, ang_limited_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("velocity_command_smoother test passed");
		else
			$display("velocity_command_smoother test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/vcs_pkg.sv
rtl/vcs_calc.sv
rtl/velocity_command_smoother.sv
bench/testbench.sv
